/* rtl/assert_macros.svh */
// Assertion macros for the bound assertion checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk, off while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Checked on every rising edge of clk, reset cycles included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

/* rtl/mbrc_pkg.sv */
package mbrc_pkg;

  // CRC-16/Modbus.
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // Frame constants.
  localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;
  localparam logic [8:0] BYTE_COUNT_MAX    = 9'd511;
  localparam logic [9:0] MIN_FRAME_LEN     = 10'd4;
  localparam logic [9:0] FRAME_OVERHEAD    = 10'd5;
  localparam logic [8:0] FIRST_DATA_POS    = 9'd3;
  localparam logic [8:0] FIRST_REG_END_POS = 9'd4;

  // Configuration register indexes.
  localparam logic CFG_SLAVE_ADDRESS  = 1'b0;
  localparam logic CFG_REGISTER_COUNT = 1'b1;

  // Result kinds.
  localparam logic KIND_REGISTER = 1'b0;
  localparam logic KIND_STATUS   = 1'b1;

  // Status codes.
  localparam logic [2:0] STATUS_OK             = 3'd0;
  localparam logic [2:0] STATUS_SHORT_OR_CRC   = 3'd1;
  localparam logic [2:0] STATUS_LENGTH         = 3'd2;
  localparam logic [2:0] STATUS_WRONG_FUNCTION = 3'd3;
  localparam logic [2:0] STATUS_WRONG_ADDRESS  = 3'd4;

  // Output item layout in m_axis_tdata.
  typedef struct packed {
    logic [5:0]  pad;
    logic [2:0]  status;
    logic [6:0]  register_index;
    logic [15:0] register_value;
  } result_data_t;

endpackage

/* rtl/mbrc_crc16.sv */
module mbrc_crc16
  import mbrc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data_byte,
  output logic [15:0] crc_out
);

  // One byte through the reflected CRC-16/Modbus, one bit per step.
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data_byte};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

/* rtl/modbus_rtu_read_response_check.sv */
// Modbus RTU read-holding-registers response checker.
// Bytes pass the input register, then their result items enter the output register.
// Throughput: one byte per cycle while the result side is not stalled; the CRC update
// and all checks are combinational between the input and result registers.
// Reset: synchronous rst clears the frame state, both stages, and sets
// slave_address and register_count to 1.
module modbus_rtu_read_response_check
  import mbrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  // Input bytes.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_frame
  // Result items.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [15:0] register_value, [22:16] register_index,
                                      // [25:23] status, [31:26] zero
  output logic        m_axis_tuser    // kind
);

  // Configuration registers.
  logic [7:0] slave_address;
  logic [6:0] register_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address  <= 8'd1;
      register_count <= 7'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS:  slave_address  <= cfg_data;
        CFG_REGISTER_COUNT: register_count <= cfg_data[6:0];
        default:            ;
      endcase
    end
  end

  // Input register and pipeline control.
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       can_move;
  logic       stage_go;

  assign can_move      = !m_axis_tvalid || m_axis_tready;
  assign stage_go      = in_valid && can_move;
  assign s_axis_tready = !in_valid || can_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  // Frame state.
  logic [15:0] crc_acc;
  logic [8:0]  byte_count;
  logic [7:0]  pending_high;
  logic        address_match;
  logic        function_match;

  logic [15:0] crc_acc_next;
  logic [8:0]  byte_count_next;
  logic [7:0]  pending_high_next;
  logic        address_match_next;
  logic        function_match_next;
  logic [15:0] crc_step;

  logic         result_valid;
  logic         result_kind;
  result_data_t result_data;

  mbrc_crc16 u_crc (
    .crc_in    (crc_acc),
    .data_byte (in_byte),
    .crc_out   (crc_step)
  );

  // Byte decode, register assembly and end-of-frame checks.
  always_comb begin
    logic [9:0] frame_len;
    logic [9:0] expected_len;
    logic [7:0] reg_idx;
    logic [8:0] reg_pos;

    frame_len    = {1'b0, byte_count} + 10'd1;
    expected_len = FRAME_OVERHEAD + {2'b00, register_count, 1'b0};
    reg_pos      = byte_count - FIRST_REG_END_POS;
    reg_idx      = reg_pos[8:1];

    crc_acc_next        = crc_step;
    byte_count_next     = byte_count;
    pending_high_next   = pending_high;
    address_match_next  = address_match;
    function_match_next = function_match;
    result_valid        = 1'b0;
    result_kind         = KIND_REGISTER;
    result_data         = '0;

    if (byte_count == 9'd0) begin
      address_match_next = (in_byte == slave_address);
    end
    if (byte_count == 9'd1) begin
      function_match_next = (in_byte == FUNC_READ_HOLDING);
    end

    if (in_last) begin
      result_valid = 1'b1;
      result_kind  = KIND_STATUS;
      if (frame_len < MIN_FRAME_LEN || crc_step != 16'd0) begin
        result_data.status = STATUS_SHORT_OR_CRC;
      end else if (frame_len != expected_len) begin
        result_data.status = STATUS_LENGTH;
      end else if (!function_match_next) begin
        result_data.status = STATUS_WRONG_FUNCTION;
      end else if (!address_match_next) begin
        result_data.status = STATUS_WRONG_ADDRESS;
      end else begin
        result_data.status = STATUS_OK;
      end
      // Back to the idle frame state.
      crc_acc_next        = CRC_INIT;
      byte_count_next     = '0;
      pending_high_next   = '0;
      address_match_next  = 1'b0;
      function_match_next = 1'b0;
    end else begin
      if (byte_count < BYTE_COUNT_MAX) begin
        byte_count_next = byte_count + 9'd1;
      end
      if (byte_count >= FIRST_DATA_POS) begin
        if (byte_count[0]) begin
          pending_high_next = in_byte;
        end else if (reg_idx < {1'b0, register_count}) begin
          result_valid                = 1'b1;
          result_data.register_value  = {pending_high, in_byte};
          result_data.register_index  = reg_idx[6:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc_acc        <= CRC_INIT;
      byte_count     <= '0;
      pending_high   <= '0;
      address_match  <= 1'b0;
      function_match <= 1'b0;
    end else if (stage_go) begin
      crc_acc        <= crc_acc_next;
      byte_count     <= byte_count_next;
      pending_high   <= pending_high_next;
      address_match  <= address_match_next;
      function_match <= function_match_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (can_move) begin
      m_axis_tvalid <= stage_go && result_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_go && result_valid) begin
      m_axis_tdata <= result_data;
      m_axis_tuser <= result_kind;
    end
  end

endmodule

/* rtl/mbrc_checker.sv */
`include "assert_macros.svh"

module mbrc_checker
  import mbrc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  logic [2:0] out_status;
  assign out_status = m_axis_tdata[25:23];

  // No result item is offered in the cycle after reset.
  `ASSERT_ALWAYS(a_idle_after_reset, rst |=> !m_axis_tvalid, "result valid after reset")

  // A stalled result item holds its contents.
  `ASSERT_CLK(a_hold_stalled,
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
    "stalled result changed")

  // A register item carries a zero status.
  `ASSERT_CLK(a_reg_status_zero,
    m_axis_tvalid && m_axis_tuser == KIND_REGISTER |-> out_status == STATUS_OK,
    "register item with status")

  // A status item carries a defined code and no register fields.
  `ASSERT_CLK(a_status_item,
    m_axis_tvalid && m_axis_tuser == KIND_STATUS |->
      m_axis_tdata[22:0] == 23'd0 && out_status <= STATUS_WRONG_ADDRESS,
    "bad status item")

endmodule

bind modbus_rtu_read_response_check mbrc_checker u_mbrc_checker (.*);

/* dv/mbrc_response_checker.sv */
`timescale 1ns / 100ps

// Shared test types and the CRC-16/Modbus byte update used by the stimulus and the checker.
package mbrc_test_pkg;
  import mbrc_pkg::*;

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
    logic [6:0]  index;
    logic [2:0]  status;
  } response_item_t;

  // One byte through the reflected CRC-16/Modbus shift register.
  function automatic logic [15:0] crc16_modbus_step(input logic [15:0] crc,
                                                    input logic [7:0] data);
    logic [15:0] acc;
    acc = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
    end
    return acc;
  endfunction
endpackage

// Watches the configuration, byte and result channels, predicts every result item
// and compares each accepted result with the oldest prediction.
module mbrc_response_checker
  import mbrc_pkg::*;
  import mbrc_test_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tlast,   // end_of_frame
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [15:0] register_value, [22:16] register_index,
                                      // [25:23] status, [31:26] zero
  input  logic        m_axis_tuser,   // kind
  output int          fail_count,
  output int          pending_results,
  output int          register_results,
  output int          status_results
);

  // Predicted frame state and configuration.
  logic [15:0] crc_acc;
  logic [8:0]  byte_pos;
  logic [7:0]  high_byte;
  logic        addr_ok;
  logic        func_ok;
  logic [7:0]  slave_addr;
  logic [6:0]  reg_count;

  response_item_t expected_results[$];
  int failures = 0;
  int registers_checked = 0;
  int statuses_checked = 0;

  task automatic clear_frame();
    crc_acc = CRC_INIT;
    byte_pos = 9'd0;
    high_byte = 8'h00;
    addr_ok = 1'b0;
    func_ok = 1'b0;
  endtask

  // Runs one received byte through the frame state and queues the result it causes.
  task automatic predict_byte(input logic [7:0] data, input logic last);
    logic [8:0]     pos;
    logic [9:0]     frame_len;
    logic [8:0]     reg_slot;
    response_item_t item;
    pos = byte_pos;
    crc_acc = crc16_modbus_step(crc_acc, data);
    if (pos == 9'd0) addr_ok = (data == slave_addr);
    if (pos == 9'd1) func_ok = (data == FUNC_READ_HOLDING);
    item = '0;
    if (last) begin
      // The status checks go in priority order; the first failing one wins.
      frame_len = {1'b0, pos} + 10'd1;
      item.kind = KIND_STATUS;
      if (frame_len < MIN_FRAME_LEN || crc_acc != 16'h0000) begin
        item.status = STATUS_SHORT_OR_CRC;
      end else if (frame_len != FRAME_OVERHEAD + {2'b00, reg_count, 1'b0}) begin
        item.status = STATUS_LENGTH;
      end else if (!func_ok) begin
        item.status = STATUS_WRONG_FUNCTION;
      end else if (!addr_ok) begin
        item.status = STATUS_WRONG_ADDRESS;
      end else begin
        item.status = STATUS_OK;
      end
      expected_results = {expected_results, item};
      clear_frame();
    end else begin
      if (byte_pos != BYTE_COUNT_MAX) byte_pos = byte_pos + 9'd1;
      // Data bytes pair up high byte first; a register goes out when its low byte lands.
      if (pos >= FIRST_DATA_POS) begin
        if (pos[0]) begin
          high_byte = data;
        end else begin
          reg_slot = (pos - FIRST_REG_END_POS) >> 1;
          if (reg_slot < {2'b00, reg_count}) begin
            item.kind = KIND_REGISTER;
            item.value = {high_byte, data};
            item.index = reg_slot[6:0];
            expected_results = {expected_results, item};
          end
        end
      end
    end
  endtask

  // Compares one accepted result item with the oldest prediction.
  task automatic check_result(input logic [31:0] tdata, input logic tuser);
    result_data_t   fields;
    response_item_t got;
    response_item_t want;
    fields = tdata;
    got.kind = tuser;
    got.value = fields.register_value;
    got.index = fields.register_index;
    got.status = fields.status;
    if (got.kind == KIND_STATUS) statuses_checked++;
    else registers_checked++;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0d value %h index %0d status %0d",
               $time, got.kind, got.value, got.index, got.status);
      failures++;
    end else begin
      want = expected_results.pop_front();
      if (got !== want) begin
        $display("%0t: result mismatch: expected kind %0d value %h index %0d status %0d",
                 $time, want.kind, want.value, want.index, want.status);
        $display("%0t:                   actual kind %0d value %h index %0d status %0d",
                 $time, got.kind, got.value, got.index, got.status);
        failures++;
      end
    end
  endtask

  // Results are checked before new bytes are predicted, since a result never
  // belongs to a byte accepted at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      slave_addr = 8'd1;
      reg_count = 7'd1;
      clear_frame();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SLAVE_ADDRESS) slave_addr = cfg_data;
        else reg_count = cfg_data[6:0];
      end
      if (m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata, m_axis_tuser);
      if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tlast);
    end
    fail_count <= failures;
    pending_results <= expected_results.size();
    register_results <= registers_checked;
    status_results <= statuses_checked;
  end

endmodule

/* dv/modbus_rtu_read_response_check_test.sv */
`timescale 1ns / 100ps

module modbus_rtu_read_response_check_test;
  import mbrc_pkg::*;
  import mbrc_test_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1250;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_index = CFG_SLAVE_ADDRESS;
  logic [7:0]  cfg_data = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tready = 1'b0;
  logic        cfg_ready;
  logic        s_axis_tready;
  logic        m_axis_tvalid;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;

  int fail_count;
  int pending_results;
  int register_results;
  int status_results;

  // Stimulus-side view of the configuration, used to shape frames.
  logic [7:0] slave_addr_now = 8'd1;
  logic [6:0] reg_count_now = 7'd1;
  logic       steady = 1'b0;
  logic [7:0] frame_buf[$];
  int bytes_sent = 0;
  int frames_sent = 0;
  int settings_used = 1;
  int cycles = 0;

  modbus_rtu_read_response_check u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  mbrc_response_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .pending_results(pending_results),
    .register_results(register_results), .status_results(status_results)
  );

  always #5 clk = ~clk;

  // The result side stalls with a probability of about one in ten, except in the steady stretch.
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic write_register(input logic idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_SLAVE_ADDRESS) slave_addr_now = data;
    else reg_count_now = data[6:0];
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops sending, waits for every predicted result, then lets the pipeline drain.
  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic append_crc();
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_buf[i]) crc = crc16_modbus_step(crc, frame_buf[i]);
    frame_buf = {frame_buf, crc[7:0]};
    frame_buf = {frame_buf, crc[15:8]};
  endtask

  // Address, function, byte count, n registers of random data, then the CRC.
  task automatic build_response(input logic [7:0] addr, input logic [7:0] func, input int n);
    frame_buf.delete();
    frame_buf = {frame_buf, addr};
    frame_buf = {frame_buf, func};
    frame_buf = {frame_buf, 8'(2 * n)};
    repeat (2 * n) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
    append_crc();
  endtask

  task automatic build_noise(input int len);
    frame_buf.delete();
    repeat (len) frame_buf = {frame_buf, 8'($urandom_range(0, 255))};
  endtask

  // Mostly well-formed responses, some corrupted, truncated or plain noise.
  task automatic build_random_frame();
    int         shape;
    int         n;
    int         pick;
    logic [7:0] addr;
    logic [7:0] func;
    shape = $urandom_range(0, 99);
    if (reg_count_now > 8) n = $urandom_range(0, 3);
    else if ($urandom_range(0, 9) < 7) n = reg_count_now;
    else n = $urandom_range(0, reg_count_now + 1);
    addr = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : slave_addr_now;
    func = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : FUNC_READ_HOLDING;
    if (shape < 85) build_response(addr, func, n);
    if (shape < 60) begin
      // Occasionally a single flipped bit breaks the CRC.
      if ($urandom_range(0, 9) == 0) begin
        pick = $urandom_range(0, frame_buf.size() - 1);
        frame_buf[pick] = frame_buf[pick] ^ (8'h01 << $urandom_range(0, 7));
      end
    end else if (shape < 75) begin
      repeat ($urandom_range(1, frame_buf.size() - 1)) void'(frame_buf.pop_back());
    end else if (shape >= 85) begin
      build_noise($urandom_range(1, 10));
      if ($urandom_range(0, 1) == 1) append_crc();
    end
  endtask

  // Sends the frame buffer one item per byte, marking the last one.
  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) begin
      @(negedge clk);
      if (!steady && $urandom_range(0, 99) < 10) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata <= frame_buf[i];
      s_axis_tlast <= (i == frame_buf.size() - 1);
      do @(posedge clk); while (!s_axis_tready);
      bytes_sent++;
    end
    frames_sent++;
  endtask

  initial begin
    int         phase;
    int         directed_items;
    logic [7:0] addr_value;
    logic [7:0] count_value;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames under the reset configuration: a lone byte, a four-byte frame
    // with a good CRC but the wrong length, a good response with extreme data bytes,
    // then a wrong function code and a wrong address.
    build_noise(1);
    send_frame();
    frame_buf.delete();
    frame_buf = {frame_buf, 8'h01};
    frame_buf = {frame_buf, FUNC_READ_HOLDING};
    append_crc();
    send_frame();
    frame_buf.delete();
    frame_buf = {frame_buf, 8'h01};
    frame_buf = {frame_buf, FUNC_READ_HOLDING};
    frame_buf = {frame_buf, 8'h02};
    frame_buf = {frame_buf, 8'h00};
    frame_buf = {frame_buf, 8'hFF};
    append_crc();
    send_frame();
    build_response(8'h01, 8'h83, 1);
    send_frame();
    build_response(8'hFE, FUNC_READ_HOLDING, 1);
    send_frame();
    directed_items = bytes_sent;

    // Random phases, each under its own register setting.
    phase = 0;
    while (bytes_sent < directed_items + RANDOM_ITEMS) begin
      settle();
      case (phase)
        0: begin
          // A count of 125, written as 8'hFD; bit 7 of the count write is ignored.
          addr_value = 8'hFF;
          count_value = 8'hFD;
        end
        1: begin
          addr_value = 8'h00;
          count_value = 8'h00;
        end
        2: begin
          addr_value = 8'($urandom_range(0, 255));
          count_value = 8'h7F;
        end
        default: begin
          addr_value = 8'($urandom_range(0, 255));
          count_value = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 6))};
        end
      endcase
      write_register(CFG_SLAVE_ADDRESS, addr_value);
      write_register(CFG_REGISTER_COUNT, count_value);
      settings_used++;
      steady = (phase == 4 || phase == 5);
      if (phase == 0) begin
        build_response(slave_addr_now, FUNC_READ_HOLDING, 125);
        send_frame();
      end else begin
        // An overlong frame runs the byte counter into saturation.
        if (phase == 2) begin
          build_noise(518);
          append_crc();
          send_frame();
        end
        repeat ($urandom_range(3, 8)) begin
          if ($urandom_range(0, 19) == 0) settle();
          build_random_frame();
          send_frame();
        end
      end
      phase++;
    end

    settle();
    $display("Sent %0d bytes in %0d frames over %0d register settings.",
             bytes_sent, frames_sent, settings_used);
    $display("Checked %0d register items and %0d status items.",
             register_results, status_results);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
